[design/cvt_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Constant value tracker package
// Shared widths, instruction and result codes, controller states and the
// truthiness rule for the constant value tracker.
// ----------------------------------------------------------------------------
package cvt_pkg;

  localparam int unsigned SLOT_COUNT = 256;
  localparam int unsigned SLOT_W     = 8;
  localparam int unsigned WORD_W     = 64;
  localparam int unsigned HALF_W     = 32;

  typedef logic [WORD_W-1:0] word_t;
  typedef logic [HALF_W-1:0] half_t;
  typedef logic [SLOT_W-1:0] slot_t;

  localparam word_t TAG_TRUE  = word_t'(7);
  localparam word_t TAG_FALSE = word_t'(3);

  typedef enum logic [3:0] {
    ACT_INT_CONST   = 4'd0,
    ACT_FLOAT_CONST = 4'd1,
    ACT_LOCAL       = 4'd2,
    ACT_ADD         = 4'd3,
    ACT_SUB         = 4'd4,
    ACT_MUL         = 4'd5,
    ACT_DIV         = 4'd6,
    ACT_EQ          = 4'd7,
    ACT_LT          = 4'd8,
    ACT_GT          = 4'd9,
    ACT_LE          = 4'd10,
    ACT_GE          = 4'd11,
    ACT_AND         = 4'd12,
    ACT_OR          = 4'd13,
    ACT_NOT         = 4'd14,
    ACT_OTHER       = 4'd15
  } action_e;

  typedef enum logic [1:0] {
    KIND_NONE = 2'd0,
    KIND_INT  = 2'd1,
    KIND_BOOL = 2'd2
  } kind_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ_B,
    ST_EXEC,
    ST_MUL,
    ST_DIV,
    ST_FINISH
  } state_e;

  // A value is false when it is zero or the tagged false pattern.
  function automatic logic truthy(word_t v);
    return (v != '0) && (v != TAG_FALSE);
  endfunction

endpackage

[design/cvt_ram.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Constant value tracker RAM
// Generic single-write, single-read synchronous RAM with registered read data.
// ----------------------------------------------------------------------------
module cvt_ram #(
  parameter int unsigned WIDTH = 64,
  parameter int unsigned DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

[design/cvt_mul.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Constant value tracker multiplier
// Low 64 bits of a 64 by 64 product from three partial products on one
// registered 32 by 32 multiplier.
// ----------------------------------------------------------------------------
module cvt_mul (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  input  cvt_pkg::word_t a_i,
  input  cvt_pkg::word_t b_i,
  output logic          done_o,
  output cvt_pkg::word_t product_o
);

  localparam int unsigned HW = cvt_pkg::HALF_W;

  cvt_pkg::word_t a_q, b_q, prod_q, acc_q;
  logic [1:0]     step_q;
  logic           busy_q, done_q;
  cvt_pkg::half_t op_x, op_y;
  cvt_pkg::word_t prod_d;

  assign op_x   = (step_q == 2'd2) ? a_q[2*HW-1:HW] : a_q[HW-1:0];
  assign op_y   = (step_q == 2'd1) ? b_q[2*HW-1:HW] : b_q[HW-1:0];
  assign prod_d = cvt_pkg::WORD_W'(op_x) * cvt_pkg::WORD_W'(op_y);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      step_q <= '0;
    end else begin
      done_q <= busy_q && (step_q == 2'd3);
      if (start_i) begin
        busy_q <= 1'b1;
        step_q <= '0;
      end else if (busy_q) begin
        step_q <= step_q + 2'd1;
        if (step_q == 2'd3) begin
          busy_q <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      a_q <= a_i;
      b_q <= b_i;
    end else if (busy_q) begin
      prod_q <= prod_d;
      unique case (step_q)
        2'd0: acc_q <= acc_q;
        2'd1: acc_q <= prod_q;
        default: acc_q <= acc_q + {prod_q[HW-1:0], {HW{1'b0}}};
      endcase
    end
  end

  assign done_o    = done_q;
  assign product_o = acc_q;

endmodule

[design/cvt_div.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Constant value tracker divider
// Signed, truncating 64-bit restoring divider producing one quotient bit per
// cycle; the most negative value divided by minus one wraps.
// ----------------------------------------------------------------------------
module cvt_div (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  input  cvt_pkg::word_t dividend_i,
  input  cvt_pkg::word_t divisor_i,
  output logic          done_o,
  output cvt_pkg::word_t quotient_o
);

  localparam int unsigned W    = cvt_pkg::WORD_W;
  localparam int unsigned CntW = $clog2(W);

  cvt_pkg::word_t rem_q, quo_q, dvs_q;
  logic           neg_q, busy_q, done_q;
  logic [CntW-1:0] cnt_q;
  logic [W:0]     shifted;
  logic [W+1:0]   diff;
  logic           ge;

  assign shifted = {rem_q, quo_q[W-1]};
  assign diff    = {1'b0, shifted} - {2'b00, dvs_q};
  assign ge      = !diff[W+1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= busy_q && (cnt_q == CntW'(W - 1));
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + CntW'(1);
        if (cnt_q == CntW'(W - 1)) begin
          busy_q <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      neg_q <= dividend_i[W-1] ^ divisor_i[W-1];
      quo_q <= dividend_i[W-1] ? (W'(0) - dividend_i) : dividend_i;
      dvs_q <= divisor_i[W-1] ? (W'(0) - divisor_i) : divisor_i;
      rem_q <= '0;
    end else if (busy_q) begin
      rem_q <= ge ? diff[W-1:0] : shifted[W-1:0];
      quo_q <= {quo_q[W-2:0], ge};
    end
  end

  assign done_o     = done_q;
  assign quotient_o = neg_q ? (W'(0) - quo_q) : quo_q;

endmodule

[design/constant_value_tracker_unit.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Constant value tracker unit
// Folds integer IR instructions to constants against a table of known slot
// values held in a synchronous RAM with flip-flop valid bits.
// ----------------------------------------------------------------------------
// One instruction word is handled at a time. Add, subtract, compare, logic,
// local and constant instructions go from acceptance until the result word
// sits in the output register and the next word can be taken through two
// slot reads on the single read port of the value RAM, an execute step and
// a write-back step, which waits while the output holds a word not yet
// taken. A multiply adds a step for its partial products on the shared 32
// by 32 multiplier, and a divide adds a step that forms one quotient bit per
// cycle. A pending result word does not block the next instruction from
// being accepted. The block-start flag clears every valid bit at once when
// its word is accepted; slot values never written read as unknown, and
// only the first 256 slots (fewer if SLOT_COUNT is smaller) hold state.
module constant_value_tracker_unit #(
  parameter int unsigned SLOT_COUNT = cvt_pkg::SLOT_COUNT
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         in_valid_i,
  output logic         in_ready_o,
  input  logic [3:0]   action_i,
  input  logic         block_start_i,
  input  logic [7:0]   dest_slot_i,
  input  logic [7:0]   src_a_slot_i,
  input  logic [7:0]   src_b_slot_i,
  input  logic signed [63:0] const_value_i,
  output logic         out_valid_o,
  input  logic         out_ready_i,
  output logic         folded_o,
  output logic [1:0]   rewritten_kind_o,
  output logic [7:0]   result_slot_o,
  output logic [31:0]  word_low_o,
  output logic [31:0]  word_high_o
);

  localparam int unsigned MaxSlots  = 1 << cvt_pkg::SLOT_W;
  localparam int unsigned SlotDepth = (SLOT_COUNT < MaxSlots) ? SLOT_COUNT : MaxSlots;
  localparam int unsigned AddrW     = $clog2(SlotDepth);
  localparam int unsigned HW        = cvt_pkg::HALF_W;

  cvt_pkg::state_e  state_q, state_d;
  cvt_pkg::action_e act_q;
  cvt_pkg::slot_t   dst_q, sa_q, sb_q;
  cvt_pkg::word_t   imm_q, a_q;
  logic [SlotDepth-1:0] known_q;

  cvt_pkg::kind_e   res_kind_q;
  cvt_pkg::word_t   res_val_q;
  logic             res_rec_q;

  logic             out_valid_q, out_folded_q;
  cvt_pkg::kind_e   out_kind_q;
  cvt_pkg::slot_t   out_slot_q;
  cvt_pkg::half_t   out_low_q, out_high_q;

  logic             in_accept, out_free, finish_load;
  logic             ram_re, ram_we;
  logic [AddrW-1:0] ram_raddr;
  cvt_pkg::word_t   ram_rdata, b_val;
  logic             sa_in, sb_in, dst_in, a_known, both;
  logic             eq_ab, slt_ab, slt_ba, bool_en, flag;
  cvt_pkg::kind_e   exec_kind;
  cvt_pkg::word_t   exec_val;
  logic             exec_rec, go_mul, go_div;
  logic             mul_start, mul_done, div_start, div_done;
  cvt_pkg::word_t   mul_prod, div_quo;

  assign in_accept = in_valid_i && in_ready_o;
  assign out_free  = !out_valid_q || out_ready_i;

  assign sa_in  = 32'(sa_q) < SlotDepth;
  assign sb_in  = 32'(sb_q) < SlotDepth;
  assign dst_in = 32'(dst_q) < SlotDepth;
  assign a_known = sa_in && known_q[AddrW'(sa_q)];
  assign both    = a_known && sb_in && known_q[AddrW'(sb_q)];
  assign b_val   = ram_rdata;

  assign eq_ab  = a_q == b_val;
  assign slt_ab = $signed(a_q) < $signed(b_val);
  assign slt_ba = $signed(b_val) < $signed(a_q);

  cvt_ram #(
    .WIDTH (cvt_pkg::WORD_W),
    .DEPTH (SlotDepth)
  ) u_value_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (AddrW'(dst_q)),
    .wdata_i (res_val_q),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  cvt_mul u_mul (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (mul_start),
    .a_i       (a_q),
    .b_i       (b_val),
    .done_o    (mul_done),
    .product_o (mul_prod)
  );

  cvt_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (a_q),
    .divisor_i  (b_val),
    .done_o     (div_done),
    .quotient_o (div_quo)
  );

  always_comb begin
    exec_kind = cvt_pkg::KIND_NONE;
    exec_val  = '0;
    exec_rec  = 1'b0;
    go_mul    = 1'b0;
    go_div    = 1'b0;
    bool_en   = 1'b0;
    flag      = 1'b0;
    unique case (act_q)
      cvt_pkg::ACT_INT_CONST: begin
        exec_val = imm_q;
        exec_rec = 1'b1;
      end
      cvt_pkg::ACT_FLOAT_CONST, cvt_pkg::ACT_OTHER: begin
        exec_rec = 1'b0;
      end
      cvt_pkg::ACT_LOCAL: begin
        if (a_known && (a_q != cvt_pkg::TAG_FALSE) && (a_q != cvt_pkg::TAG_TRUE)) begin
          exec_kind = cvt_pkg::KIND_INT;
          exec_val  = a_q;
          exec_rec  = 1'b1;
        end
      end
      cvt_pkg::ACT_ADD: begin
        if (both) begin
          exec_kind = cvt_pkg::KIND_INT;
          exec_val  = a_q + b_val;
          exec_rec  = 1'b1;
        end
      end
      cvt_pkg::ACT_SUB: begin
        if (both) begin
          exec_kind = cvt_pkg::KIND_INT;
          exec_val  = a_q - b_val;
          exec_rec  = 1'b1;
        end
      end
      cvt_pkg::ACT_MUL: go_mul = both;
      cvt_pkg::ACT_DIV: go_div = both && (b_val != '0);
      cvt_pkg::ACT_EQ: begin
        bool_en = both;
        flag    = eq_ab;
      end
      cvt_pkg::ACT_LT: begin
        bool_en = both;
        flag    = slt_ab;
      end
      cvt_pkg::ACT_GT: begin
        bool_en = both;
        flag    = slt_ba;
      end
      cvt_pkg::ACT_LE: begin
        bool_en = both;
        flag    = !slt_ba;
      end
      cvt_pkg::ACT_GE: begin
        bool_en = both;
        flag    = !slt_ab;
      end
      cvt_pkg::ACT_AND: begin
        bool_en = both;
        flag    = cvt_pkg::truthy(a_q) && cvt_pkg::truthy(b_val);
      end
      cvt_pkg::ACT_OR: begin
        bool_en = both;
        flag    = cvt_pkg::truthy(a_q) || cvt_pkg::truthy(b_val);
      end
      cvt_pkg::ACT_NOT: begin
        bool_en = a_known;
        flag    = !cvt_pkg::truthy(a_q);
      end
      default: exec_rec = 1'b0;
    endcase
    if (bool_en) begin
      exec_kind = cvt_pkg::KIND_BOOL;
      exec_val  = flag ? cvt_pkg::TAG_TRUE : cvt_pkg::TAG_FALSE;
      exec_rec  = 1'b1;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      cvt_pkg::ST_IDLE: begin
        if (in_accept) begin
          state_d = cvt_pkg::ST_READ_B;
        end
      end
      cvt_pkg::ST_READ_B: state_d = cvt_pkg::ST_EXEC;
      cvt_pkg::ST_EXEC: begin
        priority if (go_mul) begin
          state_d = cvt_pkg::ST_MUL;
        end else if (go_div) begin
          state_d = cvt_pkg::ST_DIV;
        end else begin
          state_d = cvt_pkg::ST_FINISH;
        end
      end
      cvt_pkg::ST_MUL: begin
        if (mul_done) begin
          state_d = cvt_pkg::ST_FINISH;
        end
      end
      cvt_pkg::ST_DIV: begin
        if (div_done) begin
          state_d = cvt_pkg::ST_FINISH;
        end
      end
      cvt_pkg::ST_FINISH: begin
        if (out_free) begin
          state_d = cvt_pkg::ST_IDLE;
        end
      end
      default: state_d = cvt_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready_o  = state_q == cvt_pkg::ST_IDLE;
    ram_re      = (state_q == cvt_pkg::ST_IDLE) || (state_q == cvt_pkg::ST_READ_B);
    ram_raddr   = (state_q == cvt_pkg::ST_IDLE) ? AddrW'(src_a_slot_i) : AddrW'(sb_q);
    mul_start   = (state_q == cvt_pkg::ST_EXEC) && go_mul;
    div_start   = (state_q == cvt_pkg::ST_EXEC) && go_div;
    finish_load = (state_q == cvt_pkg::ST_FINISH) && out_free;
    ram_we      = finish_load && res_rec_q && dst_in;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= cvt_pkg::ST_IDLE;
      known_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (in_accept && block_start_i) begin
        known_q <= '0;
      end else if (ram_we) begin
        known_q[AddrW'(dst_q)] <= 1'b1;
      end
      if (finish_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      act_q <= cvt_pkg::action_e'(action_i);
      dst_q <= dest_slot_i;
      sa_q  <= src_a_slot_i;
      sb_q  <= src_b_slot_i;
      imm_q <= const_value_i;
    end
    if (state_q == cvt_pkg::ST_READ_B) begin
      a_q <= ram_rdata;
    end
    if (state_q == cvt_pkg::ST_EXEC) begin
      res_kind_q <= exec_kind;
      res_val_q  <= exec_val;
      res_rec_q  <= exec_rec;
    end else if ((state_q == cvt_pkg::ST_MUL) && mul_done) begin
      res_kind_q <= cvt_pkg::KIND_INT;
      res_val_q  <= mul_prod;
      res_rec_q  <= 1'b1;
    end else if ((state_q == cvt_pkg::ST_DIV) && div_done) begin
      res_kind_q <= cvt_pkg::KIND_INT;
      res_val_q  <= div_quo;
      res_rec_q  <= 1'b1;
    end
    if (finish_load) begin
      out_folded_q <= res_kind_q != cvt_pkg::KIND_NONE;
      out_kind_q   <= res_kind_q;
      out_slot_q   <= (res_kind_q != cvt_pkg::KIND_NONE) ? dst_q : '0;
      unique case (res_kind_q)
        cvt_pkg::KIND_INT: begin
          out_low_q  <= res_val_q[HW-1:0];
          out_high_q <= res_val_q[2*HW-1:HW];
        end
        cvt_pkg::KIND_BOOL: begin
          out_low_q  <= {{(HW-1){1'b0}}, res_val_q[2]};
          out_high_q <= '0;
        end
        default: begin
          out_low_q  <= '0;
          out_high_q <= '0;
        end
      endcase
    end
  end

  assign out_valid_o      = out_valid_q;
  assign folded_o         = out_folded_q;
  assign rewritten_kind_o = out_kind_q;
  assign result_slot_o    = out_slot_q;
  assign word_low_o       = out_low_q;
  assign word_high_o      = out_high_q;

endmodule

[design/cvt_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Constant value tracker checker
// Port-level assertions on the result words and the one-at-a-time input
// acceptance of the constant value tracker unit.
// ----------------------------------------------------------------------------
module cvt_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_ready_i,
  input logic        out_valid_i,
  input logic        out_ready_i,
  input logic        folded_i,
  input logic [1:0]  rewritten_kind_i,
  input logic [7:0]  result_slot_i,
  input logic [31:0] word_low_i,
  input logic [31:0] word_high_i
);

  a_folded_kind : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> (folded_i == (rewritten_kind_i != cvt_pkg::KIND_NONE)))
    else $error("folded flag disagrees with rewritten kind");

  a_unchanged_zero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !folded_i |-> (result_slot_i == '0) && (word_low_i == '0)
      && (word_high_i == '0))
    else $error("unchanged word carries non-zero fields");

  a_bool_form : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && (rewritten_kind_i == cvt_pkg::KIND_BOOL)
      |-> (word_high_i == '0) && (word_low_i[31:1] == '0))
    else $error("boolean result is not zero or one");

  a_out_hold : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(word_low_i)
      && $stable(word_high_i) && $stable(result_slot_i))
    else $error("stalled result word changed");

  a_one_at_a_time : assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i |=> !in_ready_i)
    else $error("input accepted on consecutive cycles");

endmodule

bind constant_value_tracker_unit cvt_checker u_cvt_checker (
  .clk_i            (clk_i),
  .rst_ni           (rst_ni),
  .in_valid_i       (in_valid_i),
  .in_ready_i       (in_ready_o),
  .out_valid_i      (out_valid_o),
  .out_ready_i      (out_ready_i),
  .folded_i         (folded_o),
  .rewritten_kind_i (rewritten_kind_o),
  .result_slot_i    (result_slot_o),
  .word_low_i       (word_low_o),
  .word_high_i      (word_high_o)
);
